>>> hdl/hptm_pkg.sv
// Shared types, constants and register codes of the heading PID thruster mixer.
package hptm_pkg;

    localparam int ACC_WIDTH_DEFAULT = 40;

    localparam int ANGLE_W   = 18;
    localparam int DIFF_W    = 19;
    localparam int HEADING_W = 16;
    localparam int GAIN_W    = 16;
    localparam int DRIVE_W   = 24;
    localparam int COUNT_W   = 5;
    localparam int OFFSET_W  = 15;
    localparam int CFG_IDX_W = 3;
    localparam int MAG_W     = 64;   // holds |error_sum| at the widest accumulator

    localparam logic [COUNT_W-1:0] CAPTURE_SAMPLE = 5'd5;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT    = 5'd20;

    // 180 and 360 degrees in 1/128 degree
    localparam logic signed [ANGLE_W-1:0] HALF_TURN = 18'sd23040;
    localparam logic signed [ANGLE_W-1:0] FULL_TURN = 18'sd46080;

    // dead-band offsets: 2.1, 2.2 and 4.4 in 1/256 units
    localparam int STILL_OFFSET   = 538;
    localparam int MOVE_THRESHOLD = 563;
    localparam int MOVE_OFFSET    = 1126;

    localparam logic [60:0] KI_TERM_LIMIT = {1'b1, 60'd0};

    localparam logic OP_COMPASS = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COMPASS_KP   = 3'd0,
        REG_COMPASS_KI   = 3'd1,
        REG_COMPASS_KD   = 3'd2,
        REG_IMAGE_KP     = 3'd3,
        REG_IMAGE_KI     = 3'd4,
        REG_IMAGE_KD     = 3'd5,
        REG_CRUISE_SPEED = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0]        compass_kp;
        logic [GAIN_W-1:0]        compass_ki;
        logic [GAIN_W-1:0]        compass_kd;
        logic [GAIN_W-1:0]        image_kp;
        logic [GAIN_W-1:0]        image_ki;
        logic [GAIN_W-1:0]        image_kd;
        logic signed [GAIN_W-1:0] cruise_speed;
    } hptm_cfg_t;

    // result of the state stage for one transaction
    typedef struct packed {
        logic                      tick;
        logic                      use_image;
        logic signed [ANGLE_W-1:0] err;
        logic signed [DIFF_W-1:0]  diff;
        logic [HEADING_W-1:0]      heading;
    } hptm_track_t;

    typedef struct packed {
        logic                 tick;
        logic [HEADING_W-1:0] heading;
    } hptm_meta_t;

    // load enables of the arithmetic stages
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } hptm_load_t;

endpackage

>>> hdl/hptm_track.sv
// Heading tracking and PID state update: one transaction per load.
module hptm_track
    import hptm_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic                        opcode,
    input  logic signed [15:0]          raw_yaw,
    input  logic signed [17:0]          target_angle,
    input  logic                        use_image,
    input  logic signed [16:0]          image_x,
    output hptm_track_t                 trk,
    output logic signed [ACC_WIDTH-1:0] err_sum
);

    localparam logic signed [ACC_WIDTH-1:0] AMAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] AMIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    logic [HEADING_W-1:0]         heading_reg, heading_next;
    logic [OFFSET_W-1:0]          offset_reg, offset_next;
    logic [COUNT_W-1:0]           count_reg, count_next;
    logic signed [ACC_WIDTH-1:0]  sum_reg, sum_next;
    logic signed [ANGLE_W-1:0]    last_err_reg, last_err_next;
    hptm_track_t                  trk_reg, trk_next;

    logic [OFFSET_W-1:0]          off_use;
    logic signed [ANGLE_W-1:0]    h_raw, h_wrap1, h_wrap2;
    logic signed [ANGLE_W-1:0]    tgt0, tgt1, tgt2, err_sel;
    logic signed [DIFF_W-1:0]     diff;
    logic signed [ACC_WIDTH:0]    sum_wide;
    logic signed [ACC_WIDTH-1:0]  sum_sat;

    always_comb
    begin
        // compass path: capture reference on the sixth sample, if it is positive
        off_use = ((count_reg == CAPTURE_SAMPLE) && (raw_yaw > 16'sd0)) ?
                  raw_yaw[OFFSET_W-1:0] : offset_reg;
        h_raw   = ANGLE_W'(raw_yaw) - $signed({3'b000, off_use}) + HALF_TURN;
        h_wrap1 = (h_raw < 18'sd0) ? h_raw + FULL_TURN : h_raw;
        h_wrap2 = (h_wrap1 > FULL_TURN) ? h_wrap1 - FULL_TURN : h_wrap1;

        // control path: target held to heading until the reference is set
        tgt0 = (count_reg <= CAPTURE_SAMPLE) ? $signed({2'b00, heading_reg}) : target_angle;
        tgt1 = (tgt0 > FULL_TURN) ? tgt0 - FULL_TURN : tgt0;
        tgt2 = (tgt1 < 18'sd0) ? tgt1 + FULL_TURN : tgt1;
        err_sel = use_image ? ANGLE_W'(image_x) : tgt2 - $signed({2'b00, heading_reg});
        diff    = DIFF_W'(err_sel) - DIFF_W'(last_err_reg);

        sum_wide = (ACC_WIDTH+1)'(sum_reg) + (ACC_WIDTH+1)'(err_sel);
        if (sum_wide[ACC_WIDTH] != sum_wide[ACC_WIDTH-1])
        begin
            sum_sat = sum_wide[ACC_WIDTH] ? AMIN : AMAX;
        end
        else
        begin
            sum_sat = sum_wide[ACC_WIDTH-1:0];
        end

        heading_next  = heading_reg;
        offset_next   = offset_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        last_err_next = last_err_reg;
        trk_next      = trk_reg;

        if (load)
        begin
            trk_next.use_image = use_image;
            if (opcode == OP_COMPASS)
            begin
                offset_next  = off_use;
                heading_next = h_wrap2[HEADING_W-1:0];
                if (count_reg < COUNT_LIMIT)
                begin
                    count_next = count_reg + 5'd1;
                end
                trk_next.tick    = 1'b0;
                trk_next.err     = '0;
                trk_next.diff    = '0;
                trk_next.heading = h_wrap2[HEADING_W-1:0];
            end
            else
            begin
                sum_next         = sum_sat;
                last_err_next    = err_sel;
                trk_next.tick    = 1'b1;
                trk_next.err     = err_sel;
                trk_next.diff    = diff;
                trk_next.heading = heading_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_reg  <= '0;
            offset_reg   <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            last_err_reg <= '0;
        end
        else
        begin
            heading_reg  <= heading_next;
            offset_reg   <= offset_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            last_err_reg <= last_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        trk_reg <= trk_next;
    end

    assign trk     = trk_reg;
    assign err_sum = sum_reg;   // accumulator after the transaction held in trk_reg

endmodule

>>> hdl/hptm_mix.sv
// PID products, rounding, drive mixing and dead band: four register stages.
module hptm_mix
    import hptm_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEFAULT
)
(
    input  logic                        clk,
    input  hptm_load_t                  load,
    input  hptm_cfg_t                   cfg,
    input  hptm_track_t                 trk,
    input  logic signed [ACC_WIDTH-1:0] err_sum,
    output logic signed [DRIVE_W-1:0]   left_drive,
    output logic signed [DRIVE_W-1:0]   right_drive,
    output logic [HEADING_W-1:0]        heading,
    output logic                        drive_valid
);

    // stage 2: partial products
    hptm_meta_t          meta2_reg;
    logic                neg2_reg;
    logic signed [34:0]  pp_kp2_reg;
    logic signed [35:0]  pp_kd2_reg;
    logic [47:0]         ki_lo2_reg, ki_hi2_reg;
    // stage 3: P+D sum and saturated I term
    hptm_meta_t          meta3_reg;
    logic signed [36:0]  pd3_reg;
    logic signed [61:0]  kit3_reg;
    // stage 4: rounded PID output
    hptm_meta_t          meta4_reg;
    logic signed [51:0]  pid4_reg;
    // stage 5: result
    logic signed [DRIVE_W-1:0] left_reg, right_reg;
    logic [HEADING_W-1:0]      heading_reg;
    logic                      dvalid_reg;

    logic [GAIN_W-1:0]   kp, ki, kd;
    logic [MAG_W-1:0]    sum_ext, mag;
    logic [79:0]         prod;
    logic [60:0]         kmag;
    logic signed [61:0]  kit;
    logic signed [62:0]  p_sum;
    logic signed [53:0]  left_raw, right_raw;

    function automatic logic signed [DRIVE_W-1:0] dead_band(
        input logic signed [53:0] d,
        input logic signed [GAIN_W-1:0] cruise
    );
        logic signed [54:0] e;
        e = 55'(d);
        if (cruise == 16'sd0)
        begin
            if (d < 54'sd0)
                e = e - 55'(STILL_OFFSET);
            else if (d > 54'sd0)
                e = e + 55'(STILL_OFFSET);
        end
        else if (!cruise[GAIN_W-1])
        begin
            if (d < 54'(MOVE_THRESHOLD))
                e = e - 55'(MOVE_OFFSET);
        end
        if (e > 55'sd8388607)
            dead_band = {1'b0, {(DRIVE_W-1){1'b1}}};
        else if (e < -55'sd8388608)
            dead_band = {1'b1, {(DRIVE_W-1){1'b0}}};
        else
            dead_band = e[DRIVE_W-1:0];
    endfunction

    always_comb
    begin
        kp = trk.use_image ? cfg.image_kp : cfg.compass_kp;
        ki = trk.use_image ? cfg.image_ki : cfg.compass_ki;
        kd = trk.use_image ? cfg.image_kd : cfg.compass_kd;
        sum_ext = MAG_W'(err_sum);
        mag = err_sum[ACC_WIDTH-1] ? MAG_W'(0) - sum_ext : sum_ext;

        // |sum| * ki, clamped to 2^60
        prod = {ki_hi2_reg, 32'd0} + 80'(ki_lo2_reg);
        kmag = (prod > 80'(KI_TERM_LIMIT)) ? KI_TERM_LIMIT : prod[60:0];
        kit  = neg2_reg ? -$signed({1'b0, kmag}) : $signed({1'b0, kmag});

        // floor((P + 1024) / 2048)
        p_sum = 63'(pd3_reg) + 63'(kit3_reg) + 63'sd1024;

        left_raw  = 54'(cfg.cruise_speed) - 54'(pid4_reg);
        right_raw = 54'(cfg.cruise_speed) + 54'(pid4_reg);
    end

    always_ff @(posedge clk)
    begin
        if (load.s2)
        begin
            meta2_reg.tick    <= trk.tick;
            meta2_reg.heading <= trk.heading;
            neg2_reg          <= err_sum[ACC_WIDTH-1];
            pp_kp2_reg        <= 35'($signed({1'b0, kp})) * 35'(trk.err);
            pp_kd2_reg        <= 36'($signed({1'b0, kd})) * 36'(trk.diff);
            ki_lo2_reg        <= 48'(mag[31:0]) * 48'(ki);
            ki_hi2_reg        <= 48'(mag[63:32]) * 48'(ki);
        end
        if (load.s3)
        begin
            meta3_reg <= meta2_reg;
            pd3_reg   <= 37'(pp_kp2_reg) + 37'(pp_kd2_reg);
            kit3_reg  <= kit;
        end
        if (load.s4)
        begin
            meta4_reg <= meta3_reg;
            pid4_reg  <= p_sum[62:11];
        end
        if (load.s5)
        begin
            heading_reg <= meta4_reg.heading;
            dvalid_reg  <= meta4_reg.tick;
            left_reg    <= meta4_reg.tick ? dead_band(left_raw, cfg.cruise_speed) : '0;
            right_reg   <= meta4_reg.tick ? dead_band(right_raw, cfg.cruise_speed) : '0;
        end
    end

    assign left_drive  = left_reg;
    assign right_drive = right_reg;
    assign heading     = heading_reg;
    assign drive_valid = dvalid_reg;

endmodule

>>> hdl/heading_pid_thruster_mixer_top.sv
// Top level of the heading PID thruster mixer: handshake, configuration, pipeline.
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  ------------------------------------------
//  in       sink       in_valid / in_stall  opcode raw_yaw target_angle use_image image_x
//  out      source     out_valid/out_stall  left_drive right_drive heading drive_valid
//  cfg      sink       cfg_we               cfg_index cfg_data (no read-back)
//
//  One transaction per clock sustained while the output is not stalled; each result
//  passes the input register, state stage, three arithmetic stages and result
//  register. The 64x16 integral product, split into two 32x16 halves, sets the depth.
//  Stages advance independently: a stall on the output only holds the stages that
//  are full, so bubbles close up and a result waiting on out_stall does not stop
//  intake until every stage is full. Reset clears the controller state, the stage
//  valid flags and the gains to their default values.
module heading_pid_thruster_mixer_top
    import hptm_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // input channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      opcode,
    input  logic signed [15:0]        raw_yaw,
    input  logic signed [17:0]        target_angle,
    input  logic                      use_image,
    input  logic signed [16:0]        image_x,
    // output channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [DRIVE_W-1:0] left_drive,
    output logic signed [DRIVE_W-1:0] right_drive,
    output logic [HEADING_W-1:0]      heading,
    output logic                      drive_valid,
    // configuration
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [GAIN_W-1:0]         cfg_data
);

    localparam int NSTAGE = 6;
    localparam int LAST   = NSTAGE - 1;

    hptm_cfg_t   cfg_reg, cfg_next;
    logic [NSTAGE-1:0] valid_reg, valid_next;
    logic [NSTAGE-1:0] free, load;

    // input register (stage 0)
    logic               op_reg;
    logic signed [15:0] yaw_reg;
    logic signed [17:0] tgt_reg;
    logic               img_reg;
    logic signed [16:0] imx_reg;

    hptm_track_t                 trk;
    logic signed [ACC_WIDTH-1:0] err_sum;
    hptm_load_t                  mix_load;

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_COMPASS_KP:   cfg_next.compass_kp   = cfg_data;
                REG_COMPASS_KI:   cfg_next.compass_ki   = cfg_data;
                REG_COMPASS_KD:   cfg_next.compass_kd   = cfg_data;
                REG_IMAGE_KP:     cfg_next.image_kp     = cfg_data;
                REG_IMAGE_KI:     cfg_next.image_ki     = cfg_data;
                REG_IMAGE_KD:     cfg_next.image_kd     = cfg_data;
                REG_CRUISE_SPEED: cfg_next.cruise_speed = $signed(cfg_data);
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // stage k takes a new transaction when empty or when its occupant moves on
    always_comb
    begin
        free[LAST] = !valid_reg[LAST] || !out_stall;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            free[k] = !valid_reg[k] || free[k+1];
        end
        load[0]       = free[0] && in_valid;
        valid_next[0] = free[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NSTAGE; k++)
        begin
            load[k]       = free[k] && valid_reg[k-1];
            valid_next[k] = free[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    assign mix_load.s2 = load[2];
    assign mix_load.s3 = load[3];
    assign mix_load.s4 = load[4];
    assign mix_load.s5 = load[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg               <= '0;
            cfg_reg.compass_kp      <= 16'd573;
            cfg_reg.compass_ki      <= 16'd0;
            cfg_reg.compass_kd      <= 16'd410;
            cfg_reg.image_kp        <= 16'd0;
            cfg_reg.image_ki        <= 16'd0;
            cfg_reg.image_kd        <= 16'd0;
            cfg_reg.cruise_speed    <= 16'sd0;
        end
        else
        begin
            valid_reg <= valid_next;
            cfg_reg   <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            op_reg  <= opcode;
            yaw_reg <= raw_yaw;
            tgt_reg <= target_angle;
            img_reg <= use_image;
            imx_reg <= image_x;
        end
    end

    // state stage: heading, sample count, integral and last error
    hptm_track #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load[1]),
        .opcode       (op_reg),
        .raw_yaw      (yaw_reg),
        .target_angle (tgt_reg),
        .use_image    (img_reg),
        .image_x      (imx_reg),
        .trk          (trk),
        .err_sum      (err_sum)
    );

    // arithmetic stages and result register
    hptm_mix #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_mix (
        .clk         (clk),
        .load        (mix_load),
        .cfg         (cfg_reg),
        .trk         (trk),
        .err_sum     (err_sum),
        .left_drive  (left_drive),
        .right_drive (right_drive),
        .heading     (heading),
        .drive_valid (drive_valid)
    );

    assign in_stall  = !free[0];
    assign out_valid = valid_reg[LAST];

endmodule

>>> sim/hptm_checker.sv
// Checker for the heading PID thruster mixer: predicts each result and compares it.
`timescale 1ns / 100ps

module hptm_checker
    import hptm_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic                      opcode,
    input  logic signed [15:0]        raw_yaw,
    input  logic signed [17:0]        target_angle,
    input  logic                      use_image,
    input  logic signed [16:0]        image_x,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic signed [DRIVE_W-1:0] left_drive,
    input  logic signed [DRIVE_W-1:0] right_drive,
    input  logic [HEADING_W-1:0]      heading,
    input  logic                      drive_valid,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [GAIN_W-1:0]         cfg_data,
    output int                        mismatch_count,
    output int                        pending_count
);

    typedef struct packed {
        logic [DRIVE_W-1:0]   left;
        logic [DRIVE_W-1:0]   right;
        logic [HEADING_W-1:0] heading;
        logic                 drive_valid;
    } drive_result_t;

    localparam longint DRIVE_HI = 64'sd8388607;
    localparam longint DRIVE_LO = -64'sd8388608;

    // predictor copy of the gains
    logic [GAIN_W-1:0]        compass_p, compass_i, compass_d;
    logic [GAIN_W-1:0]        image_p, image_i, image_d;
    logic signed [GAIN_W-1:0] cruise;

    // predictor copy of the controller state
    longint heading_now;
    longint yaw_ref;
    int     sample_no;
    longint err_total;
    longint err_prev;

    drive_result_t drives_due[$];
    int            errors;
    int            results_seen;

    function automatic longint clip_drive(longint d);
        if (d > DRIVE_HI)
            return DRIVE_HI;
        if (d < DRIVE_LO)
            return DRIVE_LO;
        return d;
    endfunction

    function automatic longint dead_band_adjust(longint d);
        if (cruise == 0)
        begin
            if (d < 0)
                d = d - STILL_OFFSET;
            else if (d > 0)
                d = d + STILL_OFFSET;
        end
        else if (cruise > 0)
        begin
            if (d < MOVE_THRESHOLD)
                d = d - MOVE_OFFSET;
        end
        return clip_drive(d);
    endfunction

    // ki * error_sum, magnitude capped at 2^60
    function automatic longint integral_term(longint ki, longint total);
        longint unsigned cap;
        longint unsigned mag;
        longint unsigned prod;
        cap = longint'(KI_TERM_LIMIT);
        mag = (total < 0) ? -total : total;
        if (ki != 0 && mag > cap / ki)
            prod = cap;
        else
            prod = mag * ki;
        if (prod > cap)
            prod = cap;
        return (total < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic drive_result_t predict_drives(logic op, logic signed [15:0] yaw,
                                                      logic signed [17:0] tgt_in,
                                                      logic img,
                                                      logic signed [16:0] img_err);
        drive_result_t r;
        longint h, tgt, err, diff, p, pid, lft, rgt, acc_max, acc_min;
        longint kp, ki, kd;
        r = '0;
        if (op == OP_COMPASS)
        begin
            h = yaw;
            if (sample_no == CAPTURE_SAMPLE && h > 0)
                yaw_ref = h;
            h = h - yaw_ref + HALF_TURN;
            if (sample_no < COUNT_LIMIT)
                sample_no++;
            if (h < 0)
                h = h + FULL_TURN;
            if (h > FULL_TURN)
                h = h - FULL_TURN;
            heading_now = h;
        end
        else
        begin
            acc_max = longint'((64'd1 << (ACC_WIDTH - 1)) - 64'd1);
            acc_min = -acc_max - 1;
            if (img)
            begin
                err = img_err;
                kp = image_p;
                ki = image_i;
                kd = image_d;
            end
            else
            begin
                tgt = tgt_in;
                // target follows the heading until the reference is settled
                if (sample_no <= CAPTURE_SAMPLE)
                    tgt = heading_now;
                if (tgt > FULL_TURN)
                    tgt = tgt - FULL_TURN;
                if (tgt < 0)
                    tgt = tgt + FULL_TURN;
                err = tgt - heading_now;
                kp = compass_p;
                ki = compass_i;
                kd = compass_d;
            end
            if (err > 0 && err_total > acc_max - err)
                err_total = acc_max;
            else if (err < 0 && err_total < acc_min - err)
                err_total = acc_min;
            else
                err_total = err_total + err;
            diff = err - err_prev;
            err_prev = err;
            p = kp * err + kd * diff + integral_term(ki, err_total);
            pid = (p + 1024) >>> 11;
            lft = dead_band_adjust(longint'(cruise) - pid);
            rgt = dead_band_adjust(longint'(cruise) + pid);
            r.left = lft[DRIVE_W-1:0];
            r.right = rgt[DRIVE_W-1:0];
            r.drive_valid = 1'b1;
        end
        r.heading = heading_now[HEADING_W-1:0];
        return r;
    endfunction

    task automatic report(string what, longint want, longint got);
        errors++;
        if (errors <= 10)
            $display("%0t: result %0d, %s: expected %0d, got %0d",
                     $time, results_seen, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        drive_result_t want;
        if (!rst_n)
        begin
            compass_p = 16'd573;
            compass_i = '0;
            compass_d = 16'd410;
            image_p = '0;
            image_i = '0;
            image_d = '0;
            cruise = '0;
            heading_now = 0;
            yaw_ref = 0;
            sample_no = 0;
            err_total = 0;
            err_prev = 0;
            drives_due.delete();
            errors = 0;
            results_seen = 0;
            mismatch_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_COMPASS_KP:   compass_p = cfg_data;
                    REG_COMPASS_KI:   compass_i = cfg_data;
                    REG_COMPASS_KD:   compass_d = cfg_data;
                    REG_IMAGE_KP:     image_p = cfg_data;
                    REG_IMAGE_KI:     image_i = cfg_data;
                    REG_IMAGE_KD:     image_d = cfg_data;
                    REG_CRUISE_SPEED: cruise = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                drives_due.push_back(predict_drives(opcode, raw_yaw, target_angle,
                                                    use_image, image_x));
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (drives_due.size() == 0)
                begin
                    report("result with no transaction outstanding, heading", -1, heading);
                end
                else
                begin
                    want = drives_due.pop_front();
                    if (left_drive !== want.left)
                        report("left_drive", $signed(want.left), left_drive);
                    if (right_drive !== want.right)
                        report("right_drive", $signed(want.right), right_drive);
                    if (heading !== want.heading)
                        report("heading", want.heading, heading);
                    if (drive_valid !== want.drive_valid)
                        report("drive_valid", want.drive_valid, drive_valid);
                end
            end
            pending_count <= drives_due.size();
            mismatch_count <= errors;
        end
    end

endmodule

>>> sim/tb_top.sv
// Testbench top for the heading PID thruster mixer: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module tb_top;
    import hptm_pkg::*;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 190;
    localparam int DRAIN_CYCLES = 12;    // pipeline is six deep; allow a margin
    localparam int LONG_HOLD    = 300;   // receiver hold-off, well beyond pipeline depth

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic                      opcode;
    logic signed [15:0]        raw_yaw;
    logic signed [17:0]        target_angle;
    logic                      use_image;
    logic signed [16:0]        image_x;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
    logic [HEADING_W-1:0]      heading;
    logic                      drive_valid;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [GAIN_W-1:0]         cfg_data;

    int mismatches;
    int pending;

    // idling controls for the sender and the receiver
    bit tx_quiet;
    bit rx_quiet;
    bit rx_long_hold;

    // tallies for the closing summary
    int n_items;
    int n_samples;
    int n_ticks;
    int n_image;
    int n_settings;

    heading_pid_thruster_mixer_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .raw_yaw      (raw_yaw),
        .target_angle (target_angle),
        .use_image    (use_image),
        .image_x      (image_x),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_drive   (left_drive),
        .right_drive  (right_drive),
        .heading      (heading),
        .drive_valid  (drive_valid),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // watches both channels and the register port, predicts and compares
    hptm_checker #(
        .ACC_WIDTH (ACC_WIDTH_DEFAULT)
    ) u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .raw_yaw        (raw_yaw),
        .target_angle   (target_angle),
        .use_image      (use_image),
        .image_x        (image_x),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .left_drive     (left_drive),
        .right_drive    (right_drive),
        .heading        (heading),
        .drive_valid    (drive_valid),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatches),
        .pending_count  (pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: far beyond the slowest legal run (every transaction taking the
    // longest sender gap, the longest receiver stall and the full latency).
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver: draws a stall length per result, and once on request a very long one
    // so the pipeline fills and the block has to stall its input.
    initial
    begin : receiver
        int hold;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_long_hold)
            begin
                rx_long_hold = 1'b0;
                hold = LONG_HOLD;
            end
            else if (rx_quiet)
                hold = 0;
            else
                hold = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 16) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
        end
    end

    // One input transaction: optional idle gap, then hold the payload until taken.
    task automatic send_item(logic op, logic signed [15:0] yaw, logic signed [17:0] tgt,
                             logic img, logic signed [16:0] ix);
        int gap;
        gap = tx_quiet ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(1, 16) : 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        opcode       <= op;
        raw_yaw      <= yaw;
        target_angle <= tgt;
        use_image    <= img;
        image_x      <= ix;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        n_items++;
        if (op == OP_COMPASS)
            n_samples++;
        else
        begin
            n_ticks++;
            if (img)
                n_image++;
        end
    endtask

    // Random transaction; field extremes turn up now and then.
    task automatic send_random();
        logic              op;
        logic              img;
        logic signed [15:0] yaw;
        logic signed [17:0] tgt;
        logic signed [16:0] ix;
        op = $urandom_range(0, 1) ? OP_TICK : OP_COMPASS;
        img = ($urandom_range(0, 99) < 30);
        case ($urandom_range(0, 9))
            0:       yaw = -16'sd23040;
            1:       yaw = 16'sd23040;
            default: yaw = $urandom_range(0, 46080) - 23040;
        endcase
        case ($urandom_range(0, 9))
            0:       tgt = -18'sd46080;
            1:       tgt = 18'sd92160;
            default: tgt = $urandom_range(0, 138240) - 46080;
        endcase
        case ($urandom_range(0, 9))
            0:       ix = -17'sd46080;
            1:       ix = 17'sd46080;
            default: ix = $urandom_range(0, 92160) - 46080;
        endcase
        send_item(op, yaw, tgt, img, ix);
    endtask

    // Drop valid, wait for every outstanding result, then let the pipe settle.
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // cfg_we is left high between back-to-back writes; program_gains lowers it
    task automatic write_reg(cfg_reg_t idx, logic [GAIN_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic program_gains(logic [GAIN_W-1:0] ckp, logic [GAIN_W-1:0] cki,
                                 logic [GAIN_W-1:0] ckd, logic [GAIN_W-1:0] ikp,
                                 logic [GAIN_W-1:0] iki, logic [GAIN_W-1:0] ikd,
                                 logic [GAIN_W-1:0] speed);
        write_reg(REG_COMPASS_KP, ckp);
        write_reg(REG_COMPASS_KI, cki);
        write_reg(REG_COMPASS_KD, ckd);
        write_reg(REG_IMAGE_KP, ikp);
        write_reg(REG_IMAGE_KI, iki);
        write_reg(REG_IMAGE_KD, ikd);
        write_reg(REG_CRUISE_SPEED, speed);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        opcode       <= OP_COMPASS;
        raw_yaw      <= '0;
        target_angle <= '0;
        use_image    <= 1'b0;
        image_x      <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_COMPASS_KP;
        cfg_data     <= '0;
        tx_quiet     = 1'b0;
        rx_quiet     = 1'b0;
        rx_long_hold = 1'b0;
        n_settings   = 1;    // reset defaults count as the first setting

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part, reset gains (cruise 0, so the still dead band) ----
        // tick before any sample: target is forced to the heading, error 0
        send_item(OP_TICK, 16'sd0, 18'sd92160, 1'b0, 17'sd0);
        // image mode with zero image gains, both extremes of image_x
        send_item(OP_TICK, 16'sd0, 18'sd0, 1'b1, -17'sd46080);
        send_item(OP_TICK, 16'sd0, 18'sd0, 1'b1, 17'sd46080);
        // first five samples: no capture yet, yaw extremes and the sign boundary
        send_item(OP_COMPASS, -16'sd23040, 18'sd0, 1'b0, 17'sd0);
        send_item(OP_COMPASS, 16'sd23040, 18'sd0, 1'b0, 17'sd0);
        send_item(OP_COMPASS, 16'sd0, 18'sd0, 1'b0, 17'sd0);
        send_item(OP_COMPASS, -16'sd1, 18'sd0, 1'b0, 17'sd0);
        send_item(OP_COMPASS, 16'sd1, 18'sd0, 1'b0, 17'sd0);
        // count is at the capture point: target still follows the heading
        send_item(OP_TICK, 16'sd0, -18'sd46080, 1'b0, 17'sd0);
        // positive sample at the capture point becomes the reference
        send_item(OP_COMPASS, 16'sd23040, 18'sd0, 1'b0, 17'sd0);
        // below the reference, so the relative heading wraps up by a full turn
        send_item(OP_COMPASS, -16'sd23040, 18'sd0, 1'b0, 17'sd0);
        send_item(OP_COMPASS, 16'sd100, 18'sd0, 1'b0, 17'sd0);
        // target now live: above a full turn, negative, and the boundaries
        send_item(OP_TICK, 16'sd0, 18'sd92160, 1'b0, 17'sd0);
        send_item(OP_TICK, 16'sd0, -18'sd46080, 1'b0, 17'sd0);
        send_item(OP_TICK, 16'sd0, 18'sd46081, 1'b0, 17'sd0);
        send_item(OP_TICK, 16'sd0, -18'sd1, 1'b0, 17'sd0);
        send_item(OP_TICK, 16'sd0, 18'sd0, 1'b0, 17'sd0);
        send_item(OP_TICK, 16'sd0, 18'sd46080, 1'b0, 17'sd0);
        send_item(OP_TICK, 16'sd0, 18'sd65536, 1'b0, 17'sd0);
        send_item(OP_TICK, 16'sd0, 18'sd100, 1'b0, 17'sd0);
        send_item(OP_TICK, 16'sd0, 18'sd0, 1'b1, -17'sd1);
        send_item(OP_TICK, 16'sd0, 18'sd0, 1'b1, 17'sd0);
        send_item(OP_COMPASS, -16'sd32, 18'sd0, 1'b0, 17'sd0);
        send_item(OP_COMPASS, 16'sd12345, 18'sd0, 1'b0, 17'sd0);
        send_item(OP_TICK, 16'sd0, 18'sd1000, 1'b0, 17'sd0);
        wait_drain();

        // ---- random phases, each with its own gains and idling pattern ----
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: program_gains('0, '0, '0, '0, '0, '0, '0);
                1: program_gains('1, '1, '1, '1, '1, '1, 16'h7FFF);
                2: program_gains(16'd573, 16'd1, 16'd410, 16'd2048, 16'd2, 16'd1000,
                                 16'h8000);
                3: program_gains($urandom_range(0, 4095), $urandom_range(0, 15),
                                 $urandom_range(0, 4095), $urandom_range(0, 4095),
                                 $urandom_range(0, 15), $urandom_range(0, 4095),
                                 $urandom_range(0, 4000) - 2000);
                4: program_gains($urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, 65535));
                // integral only; a small positive cruise sits below the threshold
                5: program_gains('0, '1, '0, '0, '1, '0, 16'd300);
                6: program_gains($urandom_range(0, 1023), $urandom_range(0, 3),
                                 $urandom_range(0, 1023), $urandom_range(0, 1023),
                                 $urandom_range(0, 3), $urandom_range(0, 1023), '0);
                default: program_gains($urandom_range(0, 8191), $urandom_range(0, 63),
                                       $urandom_range(0, 8191), $urandom_range(0, 8191),
                                       $urandom_range(0, 63), $urandom_range(0, 8191),
                                       $urandom_range(0, 1200) - 600);
            endcase
            tx_quiet = phase[0];
            rx_quiet = phase[1];
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // sender keeps streaming while the receiver holds off
                if (phase == 1 && k == 50)
                    rx_long_hold = 1'b1;
                // sender pauses until every outstanding result is back
                if (phase == 4 && k == PHASE_ITEMS / 2)
                    wait_drain();
                send_random();
            end
            wait_drain();
        end

        $display("run covered %0d transactions: %0d compass samples, %0d control ticks",
                 n_items, n_samples, n_ticks);
        $display("%0d ticks on image error, %0d gain settings incl. zero and full-scale",
                 n_image, n_settings);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
hdl/hptm_pkg.sv
hdl/hptm_track.sv
hdl/hptm_mix.sv
hdl/heading_pid_thruster_mixer_top.sv
sim/hptm_checker.sv
sim/tb_top.sv
